// ===== rtl/fixed_field_real_parse_defines.svh =====
// ---------------------------------------------------------------------------
// fixed_field_real_parse assertion macros
// Concurrent assertion wrappers shared by the parser modules.
// ---------------------------------------------------------------------------
`ifndef FIXED_FIELD_REAL_PARSE_DEFINES_SVH
`define FIXED_FIELD_REAL_PARSE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FFRP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FFRP_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FFRP_ASSERT(lbl, clk, rst, prop, msg)
`define FFRP_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/ffrp_pkg.sv =====
// ---------------------------------------------------------------------------
// ffrp_pkg
// Shared widths, character codes, item types and the power-of-ten table.
// ---------------------------------------------------------------------------
package ffrp_pkg;

  localparam int FieldWidth = 8;
  localparam int NumCols    = 8;
  localparam int ScanLen    = (FieldWidth < NumCols) ? FieldWidth : NumCols;
  localparam int ColW       = 8;
  localparam int DigW       = 4;
  localparam int SigW       = 27;
  localparam int ExpW       = 21;
  localparam int UsedW      = 4;
  localparam int PosW       = 3;
  localparam int InW        = NumCols * ColW;
  localparam int OutW       = 56;
  localparam int QDepth     = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;

  localparam logic [ColW-1:0] ChNl    = 8'h0A;
  localparam logic [ColW-1:0] ChPlus  = 8'h2B;
  localparam logic [ColW-1:0] ChMinus = 8'h2D;
  localparam logic [ColW-1:0] ChDot   = 8'h2E;
  localparam logic [ColW-1:0] ChZero  = 8'h30;
  localparam logic [ColW-1:0] ChNine  = 8'h39;

  typedef struct packed {
    logic [NumCols-1:0][DigW-1:0] digit;
    logic [NumCols-1:0]           sig_mask;
    logic [NumCols-1:0]           exp_mask;
    logic [UsedW-1:0]             frac_cnt;
    logic                         neg;
    logic                         exp_neg;
    logic [UsedW-1:0]             used;
  } item_t;

  typedef struct packed {
    logic                   negative;
    logic [SigW-1:0]        significand;
    logic signed [ExpW-1:0] decimal_exponent;
    logic [UsedW-1:0]       chars_used;
  } result_t;

  function automatic logic [SigW-1:0] pow10(input logic [PosW-1:0] k);
    logic [SigW-1:0] p;
    case (k)
      3'd0:    p = 27'd1;
      3'd1:    p = 27'd10;
      3'd2:    p = 27'd100;
      3'd3:    p = 27'd1000;
      3'd4:    p = 27'd10000;
      3'd5:    p = 27'd100000;
      3'd6:    p = 27'd1000000;
      3'd7:    p = 27'd10000000;
      default: p = 27'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/ffrp_front.sv =====
// ---------------------------------------------------------------------------
// ffrp_front
// Classifies the characters of one field and routes each digit.
// ---------------------------------------------------------------------------
module ffrp_front
  import ffrp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [InW-1:0] in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output item_t          out_item
);

  logic  valid;
  item_t item;
  item_t item_next;

  always_comb begin
    logic [ColW-1:0]    c;
    logic [NumCols-1:0] act;
    logic [NumCols-1:0] fracm;
    logic               seen_nl;
    logic               exp_on;
    logic               frac_on;
    logic               is_nl;
    logic               is_dig;
    item_next = '0;
    act       = '0;
    fracm     = '0;
    seen_nl   = 1'b0;
    exp_on    = 1'b0;
    frac_on   = 1'b0;
    item_next.used = UsedW'(ScanLen);
    for (int i = 0; i < NumCols; i++) begin
      c      = in_data[i*ColW +: ColW];
      is_nl  = (i < ScanLen) && (c == ChNl);
      is_dig = c inside {[ChZero:ChNine]};
      act[i] = (i < ScanLen) && !seen_nl && !is_nl;
      if (is_nl && !seen_nl) begin
        item_next.used = UsedW'(i);
      end
      if (is_nl) begin
        seen_nl = 1'b1;
      end
      item_next.digit[i]    = is_dig ? c[DigW-1:0] : '0;
      item_next.sig_mask[i] = act[i] && is_dig && !exp_on;
      item_next.exp_mask[i] = act[i] && is_dig && exp_on;
      fracm[i]              = act[i] && is_dig && !exp_on && frac_on;
      if (act[i] && (c == ChMinus)) begin
        if (i == 0) begin
          item_next.neg = 1'b1;
        end else begin
          item_next.exp_neg = 1'b1;
        end
      end
      if (act[i] && (i != 0) && ((c == ChMinus) || (c == ChPlus))) begin
        exp_on = 1'b1;
      end
      if (act[i] && (c == ChDot)) begin
        frac_on = 1'b1;
      end
    end
    item_next.frac_cnt = UsedW'($countones(fracm));
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

// ===== rtl/ffrp_queue.sv =====
// ---------------------------------------------------------------------------
// ffrp_queue
// Short request queue between the classifier and the evaluator.
// ---------------------------------------------------------------------------
`include "fixed_field_real_parse_defines.svh"

module ffrp_queue
  import ffrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t             mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;
  logic              push;
  logic              pop;

  assign in_ready  = (count < QCntW'(QDepth));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCntW'(push) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  `FFRP_ASSERT(a_count_max, clk, rst, count <= QCntW'(QDepth), "queue count exceeds depth")
  `FFRP_ASSERT(a_count_track, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "queue count lost a push")

endmodule

// ===== rtl/ffrp_back.sv =====
// ---------------------------------------------------------------------------
// ffrp_back
// Weights routed digits by place value and sums them into the result.
// ---------------------------------------------------------------------------
`include "fixed_field_real_parse_defines.svh"

module ffrp_back
  import ffrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic                          s1_v;
  logic                          s1_ready;
  logic [NumCols-1:0][SigW-1:0]  sig_term;
  logic [NumCols-1:0][SigW-1:0]  exp_term;
  logic [NumCols-1:0][SigW-1:0]  sig_term_next;
  logic [NumCols-1:0][SigW-1:0]  exp_term_next;
  logic                          s1_neg;
  logic                          s1_exp_neg;
  logic [UsedW-1:0]              s1_frac_cnt;
  logic [UsedW-1:0]              s1_used;

  logic                          s2_v;
  logic                          s2_ready;
  result_t                       res;
  result_t                       res_next;

  assign s2_ready = !s2_v || out_ready;
  assign s1_ready = !s1_v || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    logic [PosW-1:0] ks;
    logic [PosW-1:0] ke;
    for (int i = 0; i < NumCols; i++) begin
      ks = '0;
      ke = '0;
      for (int j = i + 1; j < NumCols; j++) begin
        ks = ks + PosW'(in_item.sig_mask[j]);
        ke = ke + PosW'(in_item.exp_mask[j]);
      end
      sig_term_next[i] = in_item.sig_mask[i] ?
                         SigW'({{(SigW-DigW){1'b0}}, in_item.digit[i]} * pow10(ks)) : '0;
      exp_term_next[i] = in_item.exp_mask[i] ?
                         SigW'({{(SigW-DigW){1'b0}}, in_item.digit[i]} * pow10(ke)) : '0;
    end
  end

  always_comb begin
    logic [SigW-1:0] sig_sum;
    logic [SigW-1:0] exp_sum;
    logic [ExpW-1:0] e;
    sig_sum = '0;
    exp_sum = '0;
    for (int i = 0; i < NumCols; i++) begin
      sig_sum = sig_sum + sig_term[i];
      exp_sum = exp_sum + exp_term[i];
    end
    e = exp_sum[ExpW-1:0];
    res_next.negative         = s1_neg;
    res_next.significand      = sig_sum;
    res_next.decimal_exponent = (s1_exp_neg ? (~e + 1'b1) : e)
                                - {{(ExpW-UsedW){1'b0}}, s1_frac_cnt};
    res_next.chars_used       = s1_used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v <= in_valid;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      sig_term    <= sig_term_next;
      exp_term    <= exp_term_next;
      s1_neg      <= in_item.neg;
      s1_exp_neg  <= in_item.exp_neg;
      s1_frac_cnt <= in_item.frac_cnt;
      s1_used     <= in_item.used;
    end
    if (s2_ready && s1_v) begin
      res <= res_next;
    end
  end

  assign out_valid = s2_v;
  assign out_res   = res;

  `FFRP_ASSERT(a_s1_hold, clk, rst, (s1_v && !s2_ready) |=> s1_v, "stage one dropped a request")
  `FFRP_ASSERT_NORST(a_rst_empty, clk, rst |=> !s2_v, "result valid after reset")

endmodule

// ===== rtl/fixed_field_real_parse.sv =====
// ---------------------------------------------------------------------------
// fixed_field_real_parse
// Parses one 8-character fixed-width text field into an exact decimal real.
// ---------------------------------------------------------------------------
// One field enters per request and one result leaves per request; a new
// field is taken every clock cycle while the request queue has room. An
// accepted field is registered in the classifier, then passes through the
// request queue and two evaluation stages (place-value weighting, then the
// digit sum and exponent adjust). The four-entry queue lets the classifier
// keep taking fields while the result side is stalled, until it is full.
// Value is (negative ? -1 : 1) * significand * 10^decimal_exponent.
module fixed_field_real_parse
  import ffrp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // col_0 .. col_7, 8 bits each
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // negative, significand[27],
                                          // decimal_exponent[21], chars_used[4]
);

  logic    f_valid;
  logic    f_ready;
  item_t   f_item;
  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  result_t res;

  ffrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  ffrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  ffrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {3'b000, res.chars_used, res.decimal_exponent,
                         res.significand, res.negative};

endmodule

// ===== tb/parse_result_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// parse_result_checker
// Watches both stream channels of the fixed-width real field parser. For
// every accepted field it computes the expected sign, significand, decimal
// exponent and used-character count. It compares every accepted result,
// field by field, against the oldest outstanding expectation.
// ---------------------------------------------------------------------------
module parse_result_checker
  import ffrp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [InW-1:0]  s_tdata,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [OutW-1:0] m_tdata,
  output int              mismatches,
  output int              pending,
  output int              checked
);

  result_t parsed_q[$];
  int      err_count = 0;
  int      result_count = 0;

  function automatic result_t parse_field(input logic [InW-1:0] cols);
    result_t         r;
    logic [ColW-1:0] c;
    int unsigned     mant;
    int unsigned     expo;
    int unsigned     frac;
    int              dexp;
    int              used;
    bit              neg;
    bit              exp_on;
    bit              exp_neg;
    bit              frac_on;
    bit              stop;
    mant = 0; expo = 0; frac = 0; used = ScanLen;
    neg = 0; exp_on = 0; exp_neg = 0; frac_on = 0; stop = 0;
    for (int i = 0; i < ScanLen; i++) begin
      c = cols[i*ColW +: ColW];
      if (!stop) begin
        if (c == ChNl) begin
          used = i;
          stop = 1;
        end else if (c == ChMinus) begin
          if (i == 0) begin
            neg = 1;
          end else begin
            exp_on = 1;
            exp_neg = 1;
          end
        end else if (c == ChPlus) begin
          if (i != 0) exp_on = 1;
        end else if (c >= ChZero && c <= ChNine) begin
          if (exp_on) begin
            expo = expo * 10 + (c - ChZero);
          end else begin
            mant = mant * 10 + (c - ChZero);
            if (frac_on) frac++;
          end
        end else if (c == ChDot) begin
          frac_on = 1;
        end
      end
    end
    dexp = (exp_neg ? -int'(expo) : int'(expo)) - int'(frac);
    r.negative         = neg;
    r.significand      = mant[SigW-1:0];
    r.decimal_exponent = dexp[ExpW-1:0];
    r.chars_used       = used[UsedW-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want) begin
      if (err_count < 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      parsed_q.delete();
    end else begin
      if (s_tvalid && s_tready) parsed_q.push_back(parse_field(s_tdata));
      if (m_tvalid && m_tready) begin
        if (parsed_q.size() == 0) begin
          if (err_count < 10) $display("mismatch: result 0x%h with no request pending", m_tdata);
          err_count++;
        end else begin
          want = parsed_q.pop_front();
          compare_field("negative", m_tdata[0], want.negative);
          compare_field("significand", m_tdata[SigW:1], want.significand);
          compare_field("decimal_exponent", $signed(m_tdata[SigW+ExpW:SigW+1]),
                        want.decimal_exponent);
          compare_field("chars_used", m_tdata[SigW+ExpW+UsedW:SigW+ExpW+1], want.chars_used);
          result_count++;
        end
      end
    end
    mismatches <= err_count;
    pending    <= parsed_q.size();
    checked    <= result_count;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives text fields into the fixed-width real field parser: a directed set
// of signs, points, exponent signs, early newlines and extreme bytes, then
// random fields that are mostly well-formed numbers. Both stream sides stall
// in random bursts; a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
  import ffrp_pkg::*;

  localparam int              RandomFields = 800;
  localparam int              QuietTail    = 150;
  localparam int              CycleLimit   = 200000;
  localparam int              DrainCycles  = 12;
  localparam logic [ColW-1:0] ChSpace      = 8'h20;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  int mismatches;
  int pending;
  int checked;
  int cycles = 0;
  int sent = 0;
  int idle_odds = 0;
  bit quiet = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  fixed_field_real_parse dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  parse_result_checker parse_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [InW-1:0] text_field(input string s);
    logic [InW-1:0] f;
    for (int i = 0; i < NumCols; i++)
      f[i*ColW +: ColW] = (i < s.len()) ? s[i] : ChSpace;
    return f;
  endfunction

  function automatic logic [InW-1:0] random_field();
    logic [ColW-1:0] b [NumCols];
    logic [InW-1:0]  f;
    int              kind;
    int              body;
    int              elen;
    int              dot;
    int              r;
    kind = $urandom_range(0, 99);
    if (kind < 15) return {$urandom, $urandom};
    if (kind < 70) begin
      elen = $urandom_range(0, 3);
      body = (elen == 0) ? NumCols : NumCols - 1 - elen;
      for (int i = 0; i < NumCols; i++) b[i] = ChZero + ColW'($urandom_range(0, 9));
      case ($urandom_range(0, 3))
        0: b[0] = ChMinus;
        1: b[0] = ChPlus;
        default: ;
      endcase
      dot = $urandom_range(0, body);
      if (dot < body) b[dot] = ChDot;
      if (elen != 0) b[body] = $urandom_range(0, 1) ? ChMinus : ChPlus;
    end else begin
      for (int i = 0; i < NumCols; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50)      b[i] = ChZero + ColW'($urandom_range(0, 9));
        else if (r < 60) b[i] = ChDot;
        else if (r < 70) b[i] = ChMinus;
        else if (r < 78) b[i] = ChPlus;
        else if (r < 84) b[i] = ChNl;
        else if (r < 90) b[i] = ChSpace;
        else             b[i] = ColW'($urandom_range(0, 255));
      end
    end
    if ($urandom_range(0, 9) == 0) b[$urandom_range(0, NumCols-1)] = ChNl;
    for (int i = 0; i < NumCols; i++) f[i*ColW +: ColW] = b[i];
    return f;
  endfunction

  task automatic send_field(input logic [InW-1:0] f);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic sender_gap();
    if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // hold tready low in random bursts until the quiet tail
  initial begin
    @(negedge rst);
    forever begin
      if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    string directed [$] = '{
      "00000000", "99999999", "-9999999", "+1234567", "12.34567", ".0000001",
      "1.2.3.45", "12-3+456", "1+2-3-45", "1+999999", "1-999999", "1-2.3456",
      "12\n45-67", "\n1234567", "1.5-2\n99", "1234567\n", "-", "+", "",
      "-+5", "9.99-999", "  -12.5 "
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_odds = 3;
    foreach (directed[i]) begin
      send_field(text_field(directed[i]));
      sender_gap();
    end
    send_field('0);
    send_field('1);
    for (int i = 0; i < RandomFields; i++) begin
      if (i % 50 == 0) idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      if (i == RandomFields / 2) wait_for_results();
      quiet = (i >= RandomFields - QuietTail);
      send_field(random_field());
      sender_gap();
    end
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d fields: %0d directed (signs, points, exponent signs, newlines,",
             sent, directed.size() + 2);
    $display("blank and extreme bytes) and %0d random; %0d results compared", RandomFields,
             checked);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
